// ===== rtl/kpq_pkg.sv =====
// ----------------------------------------------------------------------------
// kpq_pkg
// Shared constants and types for the key/payload quicksort block.
// ----------------------------------------------------------------------------
package kpq_pkg;
    localparam int Depth = 64;
    localparam int IdxW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam int KeyW  = 32;
    localparam int PayW  = 64;
    localparam int EntW  = KeyW + PayW;
    localparam int StkW  = 2 * IdxW;

    localparam logic [0:0] RegDescending = 1'b0;

    typedef logic [IdxW-1:0] idx_t;

    // Sort order test: true when a goes ahead of b.
    function automatic logic goes_first(input logic desc, input logic signed [KeyW-1:0] a,
                                        input logic signed [KeyW-1:0] b);
        goes_first = desc ? (a > b) : (a < b);
    endfunction
endpackage

// ===== rtl/key_payload_quicksort.sv =====
// ----------------------------------------------------------------------------
// key_payload_quicksort
// Collects key/payload pairs, sorts them in place by Hoare quicksort, emits them.
// ----------------------------------------------------------------------------
// Loading takes one request per cycle into the entry store.
// After the request marked last, the sort runs on a single-port store: each
// partition reads its pivot, scans from both ends, swaps, pushes the two
// sub-ranges and pops the next range from the stack; many ties cost more swaps.
// Emission then reads and delivers each result, holding while out_ready is low.
// Reset (rst_n low, asynchronous) clears control state, count and overflow
// flag, and the descending register; store contents stay undefined.
module key_payload_quicksort (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [31:0]         sort_key,
    input  logic [63:0]                payload,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [31:0]         sorted_key,
    output logic [63:0]                sorted_payload,
    output logic                       last_out,
    output logic                       overflowed
);
    localparam int IdxW = kpq_pkg::IdxW;
    localparam int CntW = kpq_pkg::CntW;
    localparam int KeyW = kpq_pkg::KeyW;
    localparam int EntW = kpq_pkg::EntW;
    localparam int StkW = kpq_pkg::StkW;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_POPW  = 4'd2;
    localparam logic [3:0] S_PIVW  = 4'd3;
    localparam logic [3:0] S_IRD   = 4'd4;
    localparam logic [3:0] S_ICMP  = 4'd5;
    localparam logic [3:0] S_JRD   = 4'd6;
    localparam logic [3:0] S_JCMP  = 4'd7;
    localparam logic [3:0] S_SWJ   = 4'd8;
    localparam logic [3:0] S_SWW   = 4'd9;
    localparam logic [3:0] S_PUSH  = 4'd10;
    localparam logic [3:0] S_ERD   = 4'd11;
    localparam logic [3:0] S_EOUT  = 4'd12;
    localparam logic [3:0] S_PIVR  = 4'd13;

    logic [3:0]  state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic        desc_reg;
    logic [IdxW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    // i and j carry two extra bits (signed) so they may step one past either end
    logic signed [IdxW+1:0] i_reg, i_next, j_reg, j_next;
    logic signed [KeyW-1:0] pivot_reg, pivot_next;
    logic [EntW-1:0] ei_reg, ei_next;
    logic [CntW-1:0] sp_reg, sp_next;
    logic        pend_reg, pend_next;
    logic [IdxW-1:0] k_reg, k_next;
    logic        ov_reg, ov_next;
    logic [EntW-1:0] od_reg, od_next;
    logic        olast_reg, olast_next, oovf_reg, oovf_next;

    logic            st_we, sk_we;
    logic [IdxW-1:0] st_addr, sk_addr;
    logic [EntW-1:0] st_wdata, st_rdata;
    logic [StkW-1:0] sk_wdata, sk_rdata;

    kpq_ram #(.Width(EntW), .Depth(kpq_pkg::Depth)) u_store (
        .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
    );
    kpq_ram #(.Width(StkW), .Depth(kpq_pkg::Depth)) u_stack (
        .clk(clk), .we(sk_we), .addr(sk_addr), .wdata(sk_wdata), .rdata(sk_rdata)
    );

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {31'd0, desc_reg};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr == {kpq_pkg::RegDescending, 1'b0})
        begin
            desc_reg <= pwdata[0];
        end
    end

    assign in_ready       = (state_reg == S_LOAD);
    assign out_valid      = ov_reg;
    assign sorted_key     = od_reg[EntW-1 -: KeyW];
    assign sorted_payload = od_reg[kpq_pkg::PayW-1:0];
    assign last_out       = olast_reg;
    assign overflowed     = oovf_reg;

    logic signed [KeyW-1:0] rkey;
    logic signed [IdxW+1:0] lo_s, hi_s, n_last;
    logic [IdxW:0] mid_sum;
    assign rkey    = st_rdata[EntW-1 -: KeyW];
    assign lo_s    = $signed({2'b00, lo_reg});
    assign hi_s    = $signed({2'b00, hi_reg});
    assign n_last  = (IdxW+2)'($signed({1'b0, count_reg}) - 1);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    // Sequencer
    always_comb
    begin
        state_next = state_reg; count_next = count_reg; ovf_next = ovf_reg;
        lo_next = lo_reg; hi_next = hi_reg; i_next = i_reg; j_next = j_reg;
        pivot_next = pivot_reg; ei_next = ei_reg; sp_next = sp_reg;
        pend_next = pend_reg; k_next = k_reg; ov_next = ov_reg; od_next = od_reg;
        olast_next = olast_reg; oovf_next = oovf_reg;
        st_we = 1'b0; st_addr = i_reg[IdxW-1:0]; st_wdata = ei_reg;
        sk_we = 1'b0; sk_addr = sp_reg[IdxW-1:0]; sk_wdata = {lo_reg, hi_reg};
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_LOAD:
            begin
                st_addr = count_reg[IdxW-1:0];
                st_wdata = {sort_key, payload};
                if (in_valid)
                begin
                    if (count_reg < CntW'(kpq_pkg::Depth))
                    begin
                        st_we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        k_next = '0;
                        if (count_next >= CntW'(2))
                        begin
                            lo_next = '0;
                            hi_next = IdxW'(count_next - 1'b1);
                            sp_next = '0;
                            state_next = S_PIVR;
                        end
                        else
                        begin
                            state_next = S_ERD;
                        end
                    end
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_ERD;
                end
                else
                begin
                    sp_next = sp_reg - 1'b1;
                    sk_addr = IdxW'(sp_reg - 1'b1);
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                lo_next = sk_rdata[StkW-1 -: IdxW];
                hi_next = sk_rdata[IdxW-1:0];
                state_next = S_PIVR;
            end
            S_PIVR:
            begin
                st_addr = mid_sum[IdxW:1];
                i_next = lo_s; j_next = hi_s;
                state_next = S_PIVW;
            end
            S_PIVW:
            begin
                pivot_next = rkey;
                state_next = S_IRD;
            end
            S_IRD:
            begin
                st_addr = i_reg[IdxW-1:0];
                state_next = S_ICMP;
            end
            S_ICMP:
            begin
                ei_next = st_rdata;
                if (i_reg < hi_s && kpq_pkg::goes_first(desc_reg, rkey, pivot_reg))
                begin
                    i_next = (IdxW+2)'(i_reg + 1);
                    st_addr = IdxW'(i_reg + 1);
                end
                else
                begin
                    st_addr = j_reg[IdxW-1:0];
                    state_next = S_JCMP;
                end
            end
            S_JRD:
            begin
                st_addr = j_reg[IdxW-1:0];
                state_next = S_JCMP;
            end
            S_JCMP:
            begin
                if (j_reg > lo_s && kpq_pkg::goes_first(desc_reg, pivot_reg, rkey))
                begin
                    j_next = (IdxW+2)'(j_reg - 1);
                    st_addr = IdxW'(j_reg - 1);
                end
                else if (i_reg <= j_reg)
                begin
                    // write entry j into slot i; entry i, held in ei_reg, goes into slot j next
                    st_we = 1'b1;
                    st_addr = i_reg[IdxW-1:0];
                    st_wdata = st_rdata;
                    state_next = S_SWJ;
                end
                else
                begin
                    state_next = S_PUSH;
                    pend_next = 1'b1;
                end
            end
            S_SWJ:
            begin
                st_we = 1'b1;
                st_addr = j_reg[IdxW-1:0];
                st_wdata = ei_reg;
                i_next = (IdxW+2)'(i_reg + 1);
                j_next = (IdxW+2)'(j_reg - 1);
                state_next = S_SWW;
            end
            S_SWW:
            begin
                state_next = (i_reg <= j_reg) ? S_IRD : S_PUSH;
                pend_next = 1'b1;
            end
            S_PUSH:
            begin
                // pushes the right range (i..hi) while pend is set, then the left range (lo..j)
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (i_reg < hi_s && sp_reg < CntW'(kpq_pkg::Depth))
                    begin
                        sk_we = 1'b1;
                        sk_wdata = {IdxW'(i_reg), hi_reg};
                        sp_next = sp_reg + 1'b1;
                    end
                end
                else
                begin
                    if (lo_s < j_reg && sp_reg < CntW'(kpq_pkg::Depth))
                    begin
                        sk_we = 1'b1;
                        sk_wdata = {lo_reg, IdxW'(j_reg)};
                        sp_next = sp_reg + 1'b1;
                    end
                    state_next = S_POP;
                end
            end
            S_ERD:
            begin
                st_addr = k_reg;
                if (count_reg == '0)
                begin
                    ovf_next = 1'b0;
                    state_next = S_LOAD;
                end
                else if (!ov_reg || out_ready)
                begin
                    state_next = S_EOUT;
                end
            end
            S_EOUT:
            begin
                ov_next = 1'b1;
                od_next = st_rdata;
                oovf_next = ovf_reg;
                olast_next = ($signed({2'b00, k_reg}) == n_last);
                if ($signed({2'b00, k_reg}) == n_last)
                begin
                    count_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_LOAD;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_ERD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sp_reg    <= '0;
            pend_reg  <= 1'b0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            sp_reg    <= sp_next;
            pend_reg  <= pend_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next; hi_reg <= hi_next; i_reg <= i_next; j_reg <= j_next;
        pivot_reg <= pivot_next; ei_reg <= ei_next; od_reg <= od_next;
        olast_reg <= olast_next; oovf_reg <= oovf_next;
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(kpq_pkg::Depth)) else $error("count beyond depth");
    a_no_input_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_LOAD |-> !in_ready) else $error("ready during sort");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(od_reg))
        else $error("result changed while stalled");
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_out |=> !out_valid)
        else $error("result follows the last one without a gap");
endmodule

// ===== rtl/kpq_ram.sv =====
// ----------------------------------------------------------------------------
// kpq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module kpq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
